// ----- rtl/hbe_pkg.sv -----
// ---------------------------------------------------------------------------
// hbe_pkg
// Shared constants of the histogram binning engine.
// ---------------------------------------------------------------------------
package hbe_pkg;

    localparam int SCREEN_COLS     = 70;
    localparam int BIN_COUNT_RESET = 30;
    localparam int BAR_WIDTH_RESET = SCREEN_COLS - 4;

    // register indexes (byte address = 4 * index)
    localparam logic REG_BIN_COUNT = 1'b0;
    localparam logic REG_BAR_WIDTH = 1'b1;

    localparam int BIN_COUNT_W = 6;
    localparam int BAR_WIDTH_W = 8;

    // quotients never exceed 255: bin index <= bin count, bar <= bar width
    localparam int QUO_W  = 8;
    localparam int STEP_W = $clog2(QUO_W);

endpackage

// ----- rtl/hbe_ifs.sv -----
// ---------------------------------------------------------------------------
// hbe_ifs
// Valid/ready channels of the histogram binning engine.
// ---------------------------------------------------------------------------
interface hbe_sample_if #(
    parameter int SAMPLE_W = 16
);
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface hbe_result_if #(
    parameter int INDEX_W = 5,
    parameter int TOTAL_W = 10
);
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] bin_index;
    logic [TOTAL_W-1:0] bin_total;
    logic [7:0]         bar_length;
    logic               dropped_flag;
    logic               final_bin;

    modport source (output valid, output bin_index, output bin_total, output bar_length,
                    output dropped_flag, output final_bin, input ready);
    modport sink   (input valid, input bin_index, input bin_total, input bar_length,
                    input dropped_flag, input final_bin, output ready);
endinterface

// ----- rtl/hbe_div.sv -----
// ---------------------------------------------------------------------------
// hbe_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^QUO_W.
// ---------------------------------------------------------------------------
module hbe_div #(
    parameter int DW = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            dividend,
    input  logic [DW-1:0]            divisor,
    output logic                     done,
    output logic [hbe_pkg::QUO_W-1:0] quotient
);

    localparam int SW = DW + hbe_pkg::QUO_W;

    logic                       busy_reg;
    logic                       done_reg;
    logic [hbe_pkg::STEP_W-1:0] step_reg;
    logic [SW-1:0]              rem_reg;
    logic [SW-1:0]              dsh_reg;
    logic [hbe_pkg::QUO_W-1:0]  quo_reg;
    logic                       fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == hbe_pkg::STEP_W'(hbe_pkg::QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= SW'(dividend);
            dsh_reg <= SW'(divisor) << (hbe_pkg::QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[hbe_pkg::QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/histogram_binning_engine_core.sv -----
// ---------------------------------------------------------------------------
// histogram_binning_engine_core
// Equal-width histogram: loads samples, bins them, reports one result per bin.
// ---------------------------------------------------------------------------
// channel   dir  transfer payload
// samples   in   sample, last_sample
// results   out  bin_index, bin_total, bar_length, dropped_flag, final_bin
// apb       in   bin_count at 0x0, bar_width at 0x4
//
// Loading accepts one sample per cycle (one store write port).
// Binning: clear of the bins in use, then per stored sample a store read,
// multiply, serial divide and counter read-modify-write.
// Emit: per bin a counter read, multiply and shared serial divide.
// Samples are refused during binning and emit; results wait for ready.
// Reset is asynchronous; the sample store needs no clearing.
// ---------------------------------------------------------------------------
module histogram_binning_engine_core #(
    parameter int MAX_SAMPLES = 512,
    parameter int MAX_BINS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    hbe_sample_if.sink  samples,
    hbe_result_if.source results
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int DW_A   = SAMPLE_BITS + NB_W;
    localparam int DW_B   = hbe_pkg::BAR_WIDTH_W + CNT_W;
    localparam int DW     = (DW_A > DW_B) ? DW_A : DW_B;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIVS  = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CWR   = 4'd7;
    localparam logic [3:0] S_ERD   = 4'd8;
    localparam logic [3:0] S_EMUL  = 4'd9;
    localparam logic [3:0] S_EDIVS = 4'd10;
    localparam logic [3:0] S_EDIVW = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [hbe_pkg::BIN_COUNT_W-1:0] bin_count_reg;
    logic [hbe_pkg::BAR_WIDTH_W-1:0] bar_width_reg;

    logic [3:0]             state_reg;
    logic [CNT_W-1:0]       stored_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic                   ovf_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic [IDX_W-1:0]       bin_reg;
    logic [CNT_W-1:0]       maxcnt_reg;
    logic [DW-1:0]          prod_reg;
    logic [hbe_pkg::QUO_W-1:0] bar_reg;

    logic                   ov_reg;
    logic [IDX_W-1:0]       o_idx_reg;
    logic [CNT_W-1:0]       o_tot_reg;
    logic [7:0]             o_bar_reg;
    logic                   o_drop_reg;
    logic                   o_fin_reg;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] store_rd_reg;
    logic [CNT_W-1:0]       bins_mem [MAX_BINS];
    logic [CNT_W-1:0]       bins_rd_reg;

    logic                   take;
    logic                   full;
    logic [SAMPLE_BITS-1:0] x;
    logic [NB_W-1:0]        nb;
    logic [NB_W-1:0]        nb_m1;
    logic [SAMPLE_BITS-1:0] span;
    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          div_divisor;
    logic [hbe_pkg::QUO_W-1:0] div_q;
    logic [CNT_W-1:0]       inc;
    logic                   out_free;
    logic                   cfg_wr;
    logic                   bins_we;
    logic [IDX_W-1:0]       bins_wa;
    logic [CNT_W-1:0]       bins_wd;
    logic [IDX_W-1:0]       bins_ra;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            hbe_pkg::REG_BIN_COUNT: prdata = 32'(bin_count_reg);
            hbe_pkg::REG_BAR_WIDTH: prdata = 32'(bar_width_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= hbe_pkg::BIN_COUNT_W'(hbe_pkg::BIN_COUNT_RESET);
            bar_width_reg <= hbe_pkg::BAR_WIDTH_W'(hbe_pkg::BAR_WIDTH_RESET);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == hbe_pkg::REG_BIN_COUNT)
                bin_count_reg <= pwdata[hbe_pkg::BIN_COUNT_W-1:0];
            else
                bar_width_reg <= pwdata[hbe_pkg::BAR_WIDTH_W-1:0];
        end
    end

    // effective bin count, 1..MAX_BINS
    always_comb
    begin
        if (bin_count_reg == '0)
            nb = NB_W'(1);
        else if (32'(bin_count_reg) > MAX_BINS)
            nb = NB_W'(MAX_BINS);
        else
            nb = NB_W'(bin_count_reg);
    end
    assign nb_m1 = nb - 1'b1;

    assign x    = samples.sample;
    assign full = stored_reg == CNT_W'(MAX_SAMPLES);
    assign take = samples.valid && samples.ready;
    assign span = (max_reg > min_reg) ? (max_reg - min_reg) : '0;
    assign inc  = bins_rd_reg + 1'b1;
    assign out_free = !ov_reg || results.ready;

    assign samples.ready = state_reg == S_LOAD;

    assign div_start   = (state_reg == S_DIVS) || (state_reg == S_EDIVS);
    assign div_divisor = (state_reg == S_DIVS) ? DW'(span) : DW'(maxcnt_reg);

    hbe_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // sample store
    always_ff @(posedge clk)
    begin
        if (take && !full)
            store_mem[stored_reg[ADDR_W-1:0]] <= x;
        store_rd_reg <= store_mem[pos_reg[ADDR_W-1:0]];
    end

    // bin counters
    assign bins_we = (state_reg == S_CLEAR) || (state_reg == S_CWR);
    assign bins_wa = (state_reg == S_CLEAR) ? clr_reg : bin_reg;
    assign bins_wd = (state_reg == S_CLEAR) ? '0 : inc;
    assign bins_ra = bin_reg;

    always_ff @(posedge clk)
    begin
        if (bins_we)
            bins_mem[bins_wa] <= bins_wd;
        bins_rd_reg <= bins_mem[bins_ra];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            stored_reg <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            clr_reg    <= '0;
            bin_reg    <= '0;
            maxcnt_reg <= '0;
            prod_reg   <= '0;
            bar_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            // a new result may load in the same cycle the old one transfers
            if (state_reg == S_OUT && out_free)
                ov_reg <= 1'b1;
            else if (results.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (take)
                    begin
                        if (full)
                            ovf_reg <= 1'b1;
                        else
                        begin
                            stored_reg <= stored_reg + 1'b1;
                            if (x < min_reg)
                                min_reg <= x;
                            if (x > max_reg)
                                max_reg <= x;
                        end
                        if (samples.last_sample)
                        begin
                            clr_reg    <= '0;
                            maxcnt_reg <= '0;
                            state_reg  <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (NB_W'(clr_reg) == nb_m1)
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    prod_reg <= DW'(store_rd_reg - min_reg) * DW'(nb);
                    if (span == '0)
                    begin
                        bin_reg   <= nb_m1[IDX_W-1:0];
                        state_reg <= S_CRD;
                    end
                    else
                        state_reg <= S_DIVS;
                end
                S_DIVS:
                    state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        if (hbe_pkg::QUO_W'(nb_m1) < div_q)
                            bin_reg <= nb_m1[IDX_W-1:0];
                        else
                            bin_reg <= div_q[IDX_W-1:0];
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                    state_reg <= S_CWR;
                S_CWR:
                begin
                    if (inc > maxcnt_reg)
                        maxcnt_reg <= inc;
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg + 1'b1 == stored_reg)
                    begin
                        bin_reg   <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_ERD:
                    state_reg <= S_EMUL;
                S_EMUL:
                begin
                    prod_reg  <= DW'(bar_width_reg) * DW'(bins_rd_reg);
                    state_reg <= S_EDIVS;
                end
                S_EDIVS:
                begin
                    if (maxcnt_reg == '0)
                    begin
                        bar_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_EDIVW;
                end
                S_EDIVW:
                begin
                    if (div_done)
                    begin
                        bar_reg   <= div_q;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        if (NB_W'(bin_reg) == nb_m1)
                        begin
                            stored_reg <= '0;
                            min_reg    <= '1;
                            max_reg    <= '0;
                            ovf_reg    <= 1'b0;
                            state_reg  <= S_LOAD;
                        end
                        else
                        begin
                            bin_reg   <= bin_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            o_idx_reg  <= bin_reg;
            o_tot_reg  <= bins_rd_reg;
            o_bar_reg  <= bar_reg[7:0];
            o_drop_reg <= ovf_reg;
            o_fin_reg  <= NB_W'(bin_reg) == nb_m1;
        end
    end

    assign results.valid        = ov_reg;
    assign results.bin_index    = o_idx_reg;
    assign results.bin_total    = o_tot_reg;
    assign results.bar_length   = o_bar_reg;
    assign results.dropped_flag = o_drop_reg;
    assign results.final_bin    = o_fin_reg;

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CNT_W'(MAX_SAMPLES))
        else $error("stored sample count beyond capacity");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWR) |-> (NB_W'(bin_reg) <= nb_m1))
        else $error("bin index beyond bins in use");

    a_final_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && NB_W'(bin_reg) == nb_m1)
        |=> (ov_reg && o_fin_reg && state_reg == S_LOAD && stored_reg == '0))
        else $error("final bin did not close the set");

    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == S_LOAD))
        else $error("sample transfer outside load");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Histogram binning engine: directed sets from a stimulus table, then random
// sets with random register settings. Every bin result is checked against an
// in-bench histogram predictor; both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;

    localparam int MAX_SAMPLES = 512;
    localparam int MAX_BINS    = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = hbe_pkg::QUO_W + 20;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_BIN_COUNT, ROW_BAR_WIDTH} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        logic        last;
        logic        typed;     // last-bin total and bar typed in below
        logic [9:0]  last_total;
        logic [7:0]  last_bar;
    } stim_row_t;

    typedef struct {
        logic [4:0] idx;
        logic [9:0] total;
        logic [7:0] bar;
        logic       dropped;
        logic       fin;
    } bin_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    hbe_sample_if #(.SAMPLE_W(16)) smp ();
    hbe_result_if res ();

    histogram_binning_engine_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (smp),
        .results (res)
    );

    // histogram state mirrored in the bench
    logic [15:0] held_samples[$];
    logic [15:0] lo_seen, hi_seen;
    logic        lost_any;
    logic [5:0]  cfg_bins;
    logic [7:0]  cfg_bar;

    bin_result_t pending_bins[$];
    int errors, n_items, n_sets, n_results, cycles;
    int rx_stall;
    logic rx_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, pending_bins.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void clear_histogram_set();
        held_samples.delete();
        lo_seen  = 16'hFFFF;
        hi_seen  = 16'h0000;
        lost_any = 1'b0;
    endfunction

    // accepts one sample; on the last one, appends one expected result per bin
    function automatic void bin_sample(logic [15:0] x, logic last);
        int unsigned nb, span, slot, peak, k;
        int unsigned counts[MAX_BINS];
        bin_result_t r;
        if (held_samples.size() < MAX_SAMPLES)
        begin
            held_samples.push_back(x);
            if (x < lo_seen) lo_seen = x;
            if (x > hi_seen) hi_seen = x;
        end
        else
            lost_any = 1'b1;
        if (!last)
            return;
        nb = (cfg_bins == 0) ? 1 : (cfg_bins > MAX_BINS) ? MAX_BINS : cfg_bins;
        for (k = 0; k < MAX_BINS; k++) counts[k] = 0;
        span = (hi_seen > lo_seen) ? hi_seen - lo_seen : 0;
        foreach (held_samples[i])
        begin
            if (span == 0)
                slot = nb - 1;
            else
            begin
                slot = ((held_samples[i] - lo_seen) * nb) / span;
                if (slot > nb - 1) slot = nb - 1;
            end
            counts[slot]++;
        end
        peak = 0;
        for (k = 0; k < nb; k++)
            if (counts[k] > peak) peak = counts[k];
        for (k = 0; k < nb; k++)
        begin
            r.idx     = k[4:0];
            r.total   = counts[k][9:0];
            r.bar     = (peak == 0) ? 8'd0 : 8'((cfg_bar * counts[k]) / peak);
            r.dropped = lost_any;
            r.fin     = (k == nb - 1);
            pending_bins.push_back(r);
        end
        clear_histogram_set();
    endfunction

    // result side: random stalls, check each transfer
    always @(negedge clk)
        res.ready = (rx_stall == 0);

    always @(posedge clk)
    begin
        bin_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            n_results++;
            if (pending_bins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result bin %0d total %0d", $time,
                         res.bin_index, res.bin_total);
            end
            else
            begin
                e = pending_bins.pop_front();
                if (res.bin_index !== e.idx || res.bin_total !== e.total ||
                    res.bar_length !== e.bar || res.dropped_flag !== e.dropped ||
                    res.final_bin !== e.fin)
                begin
                    errors++;
                    $display("%0t: expected idx %0d total %0d bar %0d drop %b fin %b",
                             $time, e.idx, e.total, e.bar, e.dropped, e.fin);
                    $display("%0t: actual   idx %0d total %0d bar %0d drop %b fin %b",
                             $time, res.bin_index, res.bin_total, res.bar_length,
                             res.dropped_flag, res.final_bin);
                end
            end
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 3);
        end
        else if (rx_stall > 0)
            rx_stall--;
    end

    // entered and left at a falling edge
    task automatic send_sample(logic [15:0] x, logic last, logic no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            smp.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp.valid       = 1'b1;
        smp.sample      = x;
        smp.last_sample = last;
        do @(posedge clk); while (!smp.ready);
        bin_sample(x, last);
        n_items++;
        if (last) n_sets++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        smp.valid = 1'b0;
        while (pending_bins.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [31:0] data);
        wait_idle();
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {reg_sel, 2'b00}; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (reg_sel == hbe_pkg::REG_BIN_COUNT) cfg_bins = data[5:0];
        else                                   cfg_bar  = data[7:0];
    endtask

    stim_row_t directed[] = '{
        '{ROW_SAMPLE,    16'd0,     1'b1, 1'b1, 10'd1, 8'd66},
        '{ROW_SAMPLE,    16'hFFFF,  1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'd0,     1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'hFFFF,  1'b1, 1'b1, 10'd2, 8'd66},
        '{ROW_BIN_COUNT, 16'd0,     1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_BAR_WIDTH, 16'd255,   1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'h1234,  1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'h8000,  1'b1, 1'b1, 10'd2, 8'd255},
        '{ROW_BIN_COUNT, 16'd63,    1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'd100,   1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'd5000,  1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'd100,   1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'd2600,  1'b1, 1'b0, 10'd0, 8'd0},
        '{ROW_BAR_WIDTH, 16'd0,     1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'h00FF,  1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'hFF00,  1'b1, 1'b1, 10'd1, 8'd0},
        '{ROW_BIN_COUNT, 16'd1,     1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_BAR_WIDTH, 16'd1,     1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'h5555,  1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_SAMPLE,    16'hAAAA,  1'b1, 1'b1, 10'd2, 8'd1},
        '{ROW_BIN_COUNT, 16'd32,    1'b0, 1'b0, 10'd0, 8'd0},
        '{ROW_BAR_WIDTH, 16'd200,   1'b0, 1'b0, 10'd0, 8'd0}
    };

    initial
    begin
        int set_len, mode;
        logic [15:0] base, x;
        errors = 0; n_items = 0; n_sets = 0; n_results = 0; cycles = 0;
        rx_stall = 0; rx_quiet = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        smp.valid = 1'b0; smp.sample = '0; smp.last_sample = 1'b0;
        res.ready = 1'b0;
        cfg_bins = 6'(hbe_pkg::BIN_COUNT_RESET);
        cfg_bar  = 8'(hbe_pkg::BAR_WIDTH_RESET);
        clear_histogram_set();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            case (directed[i].kind)
                ROW_BIN_COUNT: write_reg(hbe_pkg::REG_BIN_COUNT, 32'(directed[i].value));
                ROW_BAR_WIDTH: write_reg(hbe_pkg::REG_BAR_WIDTH, 32'(directed[i].value));
                default:
                begin
                    send_sample(directed[i].value, directed[i].last, 1'b0);
                    if (directed[i].typed &&
                        (pending_bins[$].total !== directed[i].last_total ||
                         pending_bins[$].bar !== directed[i].last_bar))
                    begin
                        errors++;
                        $display("%0t: row %0d last bin expected total %0d bar %0d",
                                 $time, i, directed[i].last_total, directed[i].last_bar);
                        $display("%0t: row %0d last bin actual   total %0d bar %0d",
                                 $time, i, pending_bins[$].total, pending_bins[$].bar);
                    end
                end
            endcase
        end

        // store overflow: 512 stored, the last one dropped and flagged
        rx_quiet = 1'b1;
        for (int n = 0; n < MAX_SAMPLES + 1; n++)
            send_sample(16'($urandom), n == MAX_SAMPLES, 1'b1);
        wait_idle();
        rx_quiet = 1'b0;

        // random sets, register settings changed every few sets
        while (n_items < 160 + MAX_SAMPLES + 25)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(hbe_pkg::REG_BIN_COUNT, 32'($urandom_range(0, 63)));
                    1:       write_reg(hbe_pkg::REG_BIN_COUNT,
                                       $urandom_range(0, 1) ? 32'd32 : 32'd1);
                    2:       write_reg(hbe_pkg::REG_BAR_WIDTH, 32'($urandom_range(0, 255)));
                    default: write_reg(hbe_pkg::REG_BAR_WIDTH,
                                       $urandom_range(0, 1) ? 32'd255 : 32'd1);
                endcase
            end
            rx_quiet = ($urandom_range(0, 4) == 0);
            set_len  = $urandom_range(1, 12);
            mode     = $urandom_range(0, 3);
            base     = 16'($urandom);
            for (int n = 0; n < set_len; n++)
            begin
                case (mode)
                    0:       x = base;
                    1:       x = base + 16'($urandom_range(0, 40));
                    default: x = 16'($urandom);
                endcase
                send_sample(x, n == set_len - 1, rx_quiet);
            end
        end

        wait_idle();
        $display("%0d samples in %0d sets, %0d bin results checked, store overflow included",
                 n_items, n_sets, n_results);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- histogram_binning_engine_core.f -----
rtl/hbe_pkg.sv
rtl/hbe_ifs.sv
rtl/hbe_div.sv
rtl/histogram_binning_engine_core.sv
tb/sv/tb.sv
